// File: rtl/fixed_point_alu_q24_8_unit_defines.svh
// Assertion macros for the fixed-point ALU.
// Both macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef FIXED_POINT_ALU_Q24_8_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_UNIT_DEFINES_SVH

// This checks that a condition holds at every clock edge outside reset.
`define FPA_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// This checks that the consequent holds in the same cycle as the antecedent.
`define FPA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
package fpa_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_W_DEF = 8;

	localparam logic signed [DATA_W-1:0] MAX_RAW = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MIN_RAW = 32'sh8000_0000;

	typedef enum logic [3:0] {
		CMD_ADD  = 4'd0,
		CMD_SUB  = 4'd1,
		CMD_MUL  = 4'd2,
		CMD_DIV  = 4'd3,
		CMD_GT   = 4'd4,
		CMD_LT   = 4'd5,
		CMD_GE   = 4'd6,
		CMD_LE   = 4'd7,
		CMD_EQ   = 4'd8,
		CMD_NE   = 4'd9,
		CMD_MIN  = 4'd10,
		CMD_MAX  = 4'd11,
		CMD_INC  = 4'd12,
		CMD_DEC  = 4'd13,
		CMD_FROM = 4'd14,
		CMD_TO   = 4'd15
	} cmd_t;

	// Result of every command but a real division, plus what the divider tail needs.
	typedef struct packed {
		logic                     is_div;
		logic                     neg;
		logic signed [DATA_W-1:0] res;
		logic                     cmp;
		logic                     ovf;
		logic                     dz;
	} side_t;

endpackage

// File: rtl/fpa_front.sv
module fpa_front #(
	parameter int FRAC_W = fpa_pkg::FRAC_W_DEF,
	parameter int NW     = fpa_pkg::DATA_W + FRAC_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                req_valid,
	input  logic [3:0]                          command,
	input  logic signed [fpa_pkg::DATA_W-1:0]   operand_a,
	input  logic signed [fpa_pkg::DATA_W-1:0]   operand_b,
	output logic                                valid_s2,
	output fpa_pkg::side_t                      side_s2,
	output logic [NW-1:0]                       num_s2,
	output logic [fpa_pkg::DATA_W-1:0]          den_s2
);

	logic                                valid_s1;
	fpa_pkg::cmd_t                       cmd_s1;
	logic signed [fpa_pkg::DATA_W-1:0]   a_s1;
	logic signed [fpa_pkg::DATA_W-1:0]   b_s1;
	logic signed [2*fpa_pkg::DATA_W-1:0] prod_s1;

	fpa_pkg::side_t                      side_d;
	logic [NW-1:0]                       num_d;
	logic [fpa_pkg::DATA_W-1:0]          den_d;
	logic [fpa_pkg::DATA_W-1:0]          mag_a;
	logic signed [fpa_pkg::DATA_W:0]     sum33;
	logic signed [fpa_pkg::DATA_W:0]     dif33;
	logic signed [fpa_pkg::DATA_W:0]     inc33;
	logic signed [fpa_pkg::DATA_W:0]     dec33;
	logic [2*fpa_pkg::DATA_W-1:0]        mag_p;
	logic [2*fpa_pkg::DATA_W-1:0]        m_p;
	logic signed [fpa_pkg::DATA_W-1:0]   hi_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= fpa_pkg::cmd_t'(command);
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			prod_s1 <= operand_a * operand_b;
		end
	end

	always_comb begin
		sum33 = {a_s1[31], a_s1} + {b_s1[31], b_s1};
		dif33 = {a_s1[31], a_s1} - {b_s1[31], b_s1};
		inc33 = {a_s1[31], a_s1} + 33'sd1;
		dec33 = {a_s1[31], a_s1} - 33'sd1;
		mag_p = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
		m_p   = (mag_p + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		hi_a  = a_s1 >>> (fpa_pkg::DATA_W - 1 - FRAC_W);
		mag_a = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
		num_d = {mag_a, {FRAC_W{1'b0}}};
		den_d = b_s1[31] ? 32'(-b_s1) : 32'(b_s1);

		side_d = '0;
		case (cmd_s1)
			fpa_pkg::CMD_ADD: begin
				side_d.ovf = sum33[32] ^ sum33[31];
				side_d.res = side_d.ovf ? (sum33[32] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW)
					: sum33[31:0];
			end
			fpa_pkg::CMD_SUB: begin
				side_d.ovf = dif33[32] ^ dif33[31];
				side_d.res = side_d.ovf ? (dif33[32] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW)
					: dif33[31:0];
			end
			fpa_pkg::CMD_MUL: begin
				if (prod_s1[63]) begin
					side_d.ovf = m_p > 64'h8000_0000;
					side_d.res = side_d.ovf ? fpa_pkg::MIN_RAW : 32'(-m_p);
				end else begin
					side_d.ovf = m_p > 64'h7FFF_FFFF;
					side_d.res = side_d.ovf ? fpa_pkg::MAX_RAW : m_p[31:0];
				end
			end
			fpa_pkg::CMD_DIV: begin
				if (b_s1 == '0) begin
					side_d.dz  = 1'b1;
					side_d.res = a_s1[31] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW;
				end else begin
					side_d.is_div = 1'b1;
					side_d.neg    = a_s1[31] ^ b_s1[31];
				end
			end
			fpa_pkg::CMD_GT: side_d.cmp = a_s1 > b_s1;
			fpa_pkg::CMD_LT: side_d.cmp = a_s1 < b_s1;
			fpa_pkg::CMD_GE: side_d.cmp = a_s1 >= b_s1;
			fpa_pkg::CMD_LE: side_d.cmp = a_s1 <= b_s1;
			fpa_pkg::CMD_EQ: side_d.cmp = a_s1 == b_s1;
			fpa_pkg::CMD_NE: side_d.cmp = a_s1 != b_s1;
			fpa_pkg::CMD_MIN: side_d.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			fpa_pkg::CMD_MAX: side_d.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			fpa_pkg::CMD_INC: begin
				side_d.ovf = inc33[32] ^ inc33[31];
				side_d.res = side_d.ovf ? fpa_pkg::MAX_RAW : inc33[31:0];
			end
			fpa_pkg::CMD_DEC: begin
				side_d.ovf = dec33[32] ^ dec33[31];
				side_d.res = side_d.ovf ? fpa_pkg::MIN_RAW : dec33[31:0];
			end
			fpa_pkg::CMD_FROM: begin
				side_d.ovf = !((hi_a == '0) || (hi_a == '1));
				side_d.res = side_d.ovf ? (a_s1[31] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW)
					: (a_s1 <<< FRAC_W);
			end
			fpa_pkg::CMD_TO: side_d.res = a_s1 >>> FRAC_W;
			default: side_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_d;
			num_s2  <= num_d;
			den_s2  <= den_d;
		end
	end

endmodule

// File: rtl/fpa_div_cell.sv
module fpa_div_cell #(
	parameter int NW = fpa_pkg::DATA_W + fpa_pkg::FRAC_W_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_i,
	input  fpa_pkg::side_t             side_i,
	input  logic [fpa_pkg::DATA_W-1:0] rem_i,
	input  logic [NW-1:0]              num_i,
	input  logic [NW-1:0]              quo_i,
	input  logic [fpa_pkg::DATA_W-1:0] den_i,
	output logic                       valid_q,
	output fpa_pkg::side_t             side_q,
	output logic [fpa_pkg::DATA_W-1:0] rem_q,
	output logic [NW-1:0]              num_q,
	output logic [NW-1:0]              quo_q,
	output logic [fpa_pkg::DATA_W-1:0] den_q
);

	logic [fpa_pkg::DATA_W:0] trial;
	logic [fpa_pkg::DATA_W:0] diff;
	logic                     take;

	// One restoring step: bring down the next numerator bit and try the divisor.
	assign trial = {rem_i, num_i[NW-1]};
	assign diff  = trial - {1'b0, den_i};
	assign take  = trial >= {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			rem_q  <= take ? diff[fpa_pkg::DATA_W-1:0] : trial[fpa_pkg::DATA_W-1:0];
			num_q  <= {num_i[NW-2:0], 1'b0};
			quo_q  <= {quo_i[NW-2:0], take};
			den_q  <= den_i;
		end
	end

endmodule

// File: rtl/fixed_point_alu_q24_8_unit.sv
// Signed fixed-point ALU on 32-bit raw values with FRAC_W fraction bits (Q24.8 by default).
// Requests enter on req_valid/req_stall with command, operand_a and operand_b; a request is
// taken at a rising edge where req_valid is high and req_stall is low. Results leave on
// rsp_valid/rsp_stall with result_value, compare_true, overflow and divide_by_zero.
// Every request yields exactly one result, in request order.
// Throughput is one request per cycle for every command while req_stall is low. A result
// shows on rsp_valid after its request has passed FRAC_W + 35 registers: two front
// stages (the 32 x 32 multiplier, then the rounding and saturation of every non-dividing
// command), one divider cell per quotient bit, 32 + FRAC_W cells in all, and one output
// register that also rounds the quotient.
// Every command travels the same chain, so results keep their order.
// The whole pipeline advances together; while rsp_valid is high and rsp_stall is high it
// holds, the result stays unchanged, and req_stall is raised so no request is lost.
// Reset (arst_n low) empties every stage at once; requests still in flight are lost, none is repeated.

`include "fixed_point_alu_q24_8_unit_defines.svh"

module fixed_point_alu_q24_8_unit #(
	parameter int FRAC_W = fpa_pkg::FRAC_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [3:0]                        command,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [fpa_pkg::DATA_W-1:0] result_value,
	output logic                              compare_true,
	output logic                              overflow,
	output logic                              divide_by_zero
);

	localparam int NW = fpa_pkg::DATA_W + FRAC_W;

	logic                       en;
	logic                       v_c    [NW+1];
	fpa_pkg::side_t             side_c [NW+1];
	logic [fpa_pkg::DATA_W-1:0] rem_c  [NW+1];
	logic [NW-1:0]              num_c  [NW+1];
	logic [NW-1:0]              quo_c  [NW+1];
	logic [fpa_pkg::DATA_W-1:0] den_c  [NW+1];

	logic                              rsp_valid_q;
	logic signed [fpa_pkg::DATA_W-1:0] res_q;
	logic                              cmp_q;
	logic                              ovf_q;
	logic                              dz_q;

	logic                              round_up;
	logic [NW:0]                       q_rnd;
	logic signed [fpa_pkg::DATA_W-1:0] res_d;
	logic                              ovf_d;

	// The pipeline moves unless a finished result is being held back.
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	fpa_front #(
		.FRAC_W(FRAC_W),
		.NW    (NW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req_valid(req_valid),
		.command  (command),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.valid_s2 (v_c[0]),
		.side_s2  (side_c[0]),
		.num_s2   (num_c[0]),
		.den_s2   (den_c[0])
	);

	assign rem_c[0] = '0;
	assign quo_c[0] = '0;

	// Each cell settles one quotient bit, most significant first.
	for (genvar i = 0; i < NW; i++) begin : g_cell
		fpa_div_cell #(
			.NW(NW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(v_c[i]),
			.side_i (side_c[i]),
			.rem_i  (rem_c[i]),
			.num_i  (num_c[i]),
			.quo_i  (quo_c[i]),
			.den_i  (den_c[i]),
			.valid_q(v_c[i+1]),
			.side_q (side_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.num_q  (num_c[i+1]),
			.quo_q  (quo_c[i+1]),
			.den_q  (den_c[i+1])
		);
	end

	// Round to nearest with ties away from zero: add one when twice the remainder reaches
	// the divisor. The sign is applied afterwards and the magnitude is saturated.
	always_comb begin
		round_up = {rem_c[NW], 1'b0} >= {1'b0, den_c[NW]};
		q_rnd    = {1'b0, quo_c[NW]} + (NW+1)'(round_up);
		res_d    = side_c[NW].res;
		ovf_d    = side_c[NW].ovf;
		if (side_c[NW].is_div) begin
			if (side_c[NW].neg) begin
				ovf_d = q_rnd > (NW+1)'(33'h1_0000_0000 >> 1);
				res_d = ovf_d ? fpa_pkg::MIN_RAW : 32'(-q_rnd[fpa_pkg::DATA_W-1:0]);
			end else begin
				ovf_d = q_rnd > (NW+1)'(fpa_pkg::MAX_RAW);
				res_d = ovf_d ? fpa_pkg::MAX_RAW : q_rnd[fpa_pkg::DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= v_c[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
			cmp_q <= side_c[NW].cmp;
			ovf_q <= ovf_d;
			dz_q  <= side_c[NW].dz;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign result_value   = res_q;
	assign compare_true   = cmp_q;
	assign overflow       = ovf_q;
	assign divide_by_zero = dz_q;

	// A division by zero is never also an overflow or a comparison.
	`FPA_IMPLY(a_dz_alone, rsp_valid && divide_by_zero, !overflow && !compare_true, "dz flag")
	// A comparison result carries a zero value and no overflow.
	`FPA_IMPLY(a_cmp_zero, rsp_valid && compare_true, result_value == '0 && !overflow, "cmp value")
	// Saturation always lands on one of the two range limits.
	`FPA_IMPLY(a_ovf_limit, rsp_valid && overflow, result_value[30:0] == {31{!result_value[31]}}, "ovf")
	// Requests are held back exactly while a result waits.
	`FPA_CHECK(a_stall_link, req_stall == (rsp_valid && rsp_stall), "stall mismatch")

endmodule
